[hdl/lmn_pkg.sv]
// Shared types, constants and codes for the Lamport mutex node.
`timescale 1ns / 1ps

package lmn_pkg;

  localparam int MAX_NODES = 16;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int ID_W      = 8;
  localparam int TS_W      = 32;
  localparam int PEER_W    = 4;
  localparam int RESP_W    = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  typedef enum logic [2:0] {
    OP_LOCK    = 3'd0,
    OP_UNLOCK  = 3'd1,
    OP_REQUEST = 3'd2,
    OP_RESP    = 3'd3,
    OP_RELEASE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    SEND_NONE    = 2'd0,
    SEND_REQUEST = 2'd1,
    SEND_RELEASE = 2'd2,
    SEND_RESP    = 2'd3
  } send_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ID     = 1'd0,
    CFG_PEER_COUNT = 1'd1
  } cfg_reg_t;

  typedef enum logic {
    T_IDLE = 1'b0,
    T_WORK = 1'b1
  } top_state_t;

  typedef enum logic [1:0] {
    L_IDLE  = 2'd0,
    L_INS   = 2'd1,
    L_FIND  = 2'd2,
    L_SHIFT = 2'd3
  } lst_state_t;

  typedef enum logic {
    LST_INSERT = 1'b0,
    LST_REMOVE = 1'b1
  } lst_op_t;

  typedef struct packed {
    logic [2:0]      operation;
    logic [ID_W-1:0] sender_id;
    logic [TS_W-1:0] msg_timestamp;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      send_kind;
    logic [ID_W-1:0] dest_id;
    logic [TS_W-1:0] out_timestamp;
    logic            in_critical;
    logic            list_overflow;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [TS_W-1:0] ts;
  } entry_t;

  typedef struct packed {
    logic    start;
    lst_op_t op;
    entry_t  key;
  } lst_cmd_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  head_id;
  } lst_stat_t;

endpackage

[hdl/lmn_list.sv]
// Sorted request list: insert and remove walk the entries one per cycle.
`timescale 1ns / 1ps

module lmn_list (
  input  logic              clk,
  input  logic              rst_n,
  input  lmn_pkg::lst_cmd_t cmd,
  output lmn_pkg::lst_stat_t stat
);
  import lmn_pkg::*;

  entry_t           ent_r [MAX_NODES];
  lst_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  entry_t           key_r, key_nxt;

  logic [CNT_W-1:0] rd_idx;
  entry_t           rd;
  logic             gt;
  logic             idx_zero;
  logic             idx_end;
  logic             we;
  logic [IDX_W-1:0] wa;
  entry_t           wd;

  // Insert walks down from the tail, so it reads the entry below the slot.
  assign rd_idx   = (state_r == L_INS) ? idx_r - CNT_W'(1) : idx_r;
  assign rd       = ent_r[rd_idx[IDX_W-1:0]];
  assign gt       = (rd.ts > key_r.ts) || ((rd.ts == key_r.ts) && (rd.id > key_r.id));
  assign idx_zero = (idx_r == '0);
  assign idx_end  = (idx_r == cnt_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      L_IDLE: begin
        if (cmd.start) begin
          state_nxt = (cmd.op == LST_INSERT) ? L_INS : L_FIND;
        end
      end
      L_INS: begin
        if (idx_zero || !gt) begin
          state_nxt = L_IDLE;
        end
      end
      L_FIND: begin
        if (idx_end) begin
          state_nxt = L_IDLE;
        end else if (rd.id == key_r.id) begin
          state_nxt = L_SHIFT;
        end
      end
      L_SHIFT: begin
        if (idx_end) begin
          state_nxt = L_IDLE;
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    key_nxt = key_r;
    we      = 1'b0;
    wa      = idx_r[IDX_W-1:0];
    wd      = rd;
    case (state_r)
      L_IDLE: begin
        if (cmd.start) begin
          key_nxt = cmd.key;
          idx_nxt = (cmd.op == LST_INSERT) ? cnt_r : '0;
        end
      end
      L_INS: begin
        we = 1'b1;
        if (idx_zero || !gt) begin
          wd      = key_r;
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          idx_nxt = idx_r - CNT_W'(1);
        end
      end
      L_FIND: begin
        if (!idx_end) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      L_SHIFT: begin
        if (idx_end) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          // pull the entry one slot toward the head
          we      = 1'b1;
          wa      = rd_idx[IDX_W-1:0] - IDX_W'(1);
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (we) begin
      ent_r[wa] <= wd;
    end
  end

  assign stat.busy    = (state_r != L_IDLE);
  assign stat.count   = cnt_r;
  assign stat.head_id = ent_r[0].id;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_NODES))
    else $error("request list count above capacity");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> state_r == L_IDLE)
    else $error("list command issued while busy");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && cmd.op == LST_INSERT) |-> cnt_r < CNT_W'(MAX_NODES))
    else $error("insert started on a full list");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == L_FIND || state_r == L_SHIFT) |-> idx_r <= cnt_r)
    else $error("scan index past list end");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == L_INS && state_nxt == L_IDLE) |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("insert did not grow the list");
`endif

endmodule

[hdl/lamport_mutex_node_top.sv]
// Top level of one Lamport mutual exclusion node.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | in_item  (operation, sender, timestamp)
//  out     | output    | out_valid / out_stall | out_item (send, dest, stamp, flags)
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// A request is taken in T_IDLE and held in T_WORK while an insert or remove scans
// the request list one entry per cycle; its result then goes to the output register.
// in_stall is high while a request is in work; the next one is taken as soon
// as the result sits in the output register, even if out_stall holds it.
// Reset (rst_n, synchronous) clears clock, counts and config; list contents are
// left as they are and only entries below the count are ever read.
`timescale 1ns / 1ps

module lamport_mutex_node_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lmn_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lmn_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  logic [lmn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lmn_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import lmn_pkg::*;

  top_state_t        state_r, state_nxt;
  logic [ID_W-1:0]   own_id_r;
  logic [PEER_W-1:0] peer_r;
  logic [TS_W-1:0]   clock_r, clock_nxt;
  logic [RESP_W-1:0] resp_r, resp_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [ID_W-1:0]   dest_r, dest_nxt;
  logic [TS_W-1:0]   ots_r, ots_nxt;
  logic              ovf_r, ovf_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  lst_cmd_t          cmd;
  lst_stat_t         lst_stat;

  logic              accept;
  logic              load;
  logic              full;
  logic              crit_now;
  logic [TS_W-1:0]   clk_inc;
  logic [TS_W-1:0]   merge_max;
  logic [TS_W-1:0]   merge_inc;

  lmn_list u_list (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .stat (lst_stat)
  );

  assign accept    = (state_r == T_IDLE) && in_valid;
  assign load      = (state_r == T_WORK) && !lst_stat.busy && (!out_valid_r || !out_stall);
  assign full      = (lst_stat.count == CNT_W'(MAX_NODES));
  assign crit_now  = (lst_stat.count != '0) && (resp_r == {1'b0, peer_r}) &&
                     (lst_stat.head_id == own_id_r);
  assign clk_inc   = clock_r + TS_W'(1);
  assign merge_max = (clock_r > in_item.msg_timestamp) ? clock_r : in_item.msg_timestamp;
  assign merge_inc = merge_max + TS_W'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          state_nxt = T_WORK;
        end
      end
      T_WORK: begin
        if (load) begin
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    clock_nxt   = clock_r;
    resp_nxt    = resp_r;
    kind_nxt    = kind_r;
    dest_nxt    = dest_r;
    ots_nxt     = ots_r;
    ovf_nxt     = ovf_r;
    cmd.start   = 1'b0;
    cmd.op      = LST_INSERT;
    cmd.key.id  = own_id_r;
    cmd.key.ts  = clk_inc;
    if (accept) begin
      kind_nxt = SEND_NONE;
      dest_nxt = '0;
      ots_nxt  = '0;
      ovf_nxt  = 1'b0;
      case (in_item.operation)
        OP_LOCK: begin
          clock_nxt = clk_inc;
          kind_nxt  = SEND_REQUEST;
          ots_nxt   = clk_inc;
          ovf_nxt   = full;
          cmd.start = !full;
        end
        OP_UNLOCK: begin
          if (crit_now) begin
            clock_nxt  = clk_inc;
            kind_nxt   = SEND_RELEASE;
            ots_nxt    = clk_inc;
            resp_nxt   = '0;
            cmd.start  = 1'b1;
            cmd.op     = LST_REMOVE;
          end
        end
        OP_REQUEST: begin
          clock_nxt  = merge_inc;
          kind_nxt   = SEND_RESP;
          dest_nxt   = in_item.sender_id;
          ots_nxt    = merge_inc;
          ovf_nxt    = full;
          cmd.start  = !full;
          cmd.key.id = in_item.sender_id;
          cmd.key.ts = in_item.msg_timestamp;
        end
        OP_RESP: begin
          clock_nxt = merge_inc;
          if (resp_r != '1) begin
            resp_nxt = resp_r + RESP_W'(1);
          end
        end
        OP_RELEASE: begin
          clock_nxt  = merge_inc;
          cmd.start  = 1'b1;
          cmd.op     = LST_REMOVE;
          cmd.key.id = in_item.sender_id;
        end
        default: ;
      endcase
    end
  end

  // critical status is taken once the list walk has settled
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt         = 1'b1;
      out_nxt.send_kind     = kind_r;
      out_nxt.dest_id       = dest_r;
      out_nxt.out_timestamp = ots_r;
      out_nxt.in_critical   = crit_now;
      out_nxt.list_overflow = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      own_id_r    <= '0;
      peer_r      <= '0;
      clock_r     <= '0;
      resp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clock_r     <= clock_nxt;
      resp_r      <= resp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_ID:     own_id_r <= cfg_data;
          CFG_PEER_COUNT: peer_r   <= cfg_data[PEER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    dest_r <= dest_nxt;
    ots_r  <= ots_nxt;
    ovf_r  <= ovf_nxt;
    out_r  <= out_nxt;
  end

  assign in_stall  = (state_r != T_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_list_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !lst_stat.busy)
    else $error("request accepted while list walk still running");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !lst_stat.busy && state_r == T_WORK)
    else $error("result loaded before list settled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result changed or dropped");
`endif

endmodule

[tb/lmn_checker.sv]
// Checker for the Lamport mutex node: tracks node state and compares each result.
`timescale 1ns / 1ps

module lmn_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  lmn_pkg::in_item_t             in_item,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  lmn_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [lmn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmn_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                            errors,
  output int                            outstanding,
  output int                            results,
  output int                            crit_seen,
  output int                            rel_seen,
  output int                            ovf_seen,
  output logic [lmn_pkg::TS_W-1:0]      clock_now,
  output int                            list_len,
  output logic [lmn_pkg::ID_W-1:0]      list_head,
  output int                            acks_now
);
  import lmn_pkg::*;

  localparam int ACK_LIMIT = (1 << RESP_W) - 1;

  logic [ID_W-1:0]   node_id;
  logic [PEER_W-1:0] peers;
  logic [TS_W-1:0]   lclock;
  logic [ID_W-1:0]   q_id [MAX_NODES];
  logic [TS_W-1:0]   q_ts [MAX_NODES];
  int                q_len;
  int                acks;
  out_item_t         pending_results[$];
  out_item_t         oldest;

  function automatic logic [TS_W-1:0] merged(input logic [TS_W-1:0] ts);
    return ((lclock > ts) ? lclock : ts) + 1'b1;
  endfunction

  // Sorted by stamp, then id; a new entry goes behind equal keys.
  function automatic bit enqueue(input logic [ID_W-1:0] id, input logic [TS_W-1:0] ts);
    int pos;
    int k;
    if (q_len >= MAX_NODES) return 1'b0;
    pos = 0;
    while (pos < q_len && (q_ts[pos] < ts || (q_ts[pos] == ts && q_id[pos] <= id)))
      pos++;
    for (k = q_len; k > pos; k--) begin
      q_id[k] = q_id[k-1];
      q_ts[k] = q_ts[k-1];
    end
    q_id[pos] = id;
    q_ts[pos] = ts;
    q_len++;
    return 1'b1;
  endfunction

  function automatic void dequeue(input logic [ID_W-1:0] id);
    int pos;
    int k;
    pos = 0;
    while (pos < q_len && q_id[pos] != id) pos++;
    if (pos >= q_len) return;
    for (k = pos; k + 1 < q_len; k++) begin
      q_id[k] = q_id[k+1];
      q_ts[k] = q_ts[k+1];
    end
    q_len--;
  endfunction

  function automatic bit holds_lock();
    return q_len > 0 && acks == peers && q_id[0] == node_id;
  endfunction

  function automatic out_item_t step_node(input in_item_t it);
    out_item_t r;
    r = '0;
    case (it.operation)
      OP_LOCK: begin
        lclock = lclock + 1'b1;
        r.list_overflow = !enqueue(node_id, lclock);
        r.send_kind     = SEND_REQUEST;
        r.out_timestamp = lclock;
      end
      OP_UNLOCK: begin
        if (holds_lock()) begin
          lclock = lclock + 1'b1;
          r.send_kind     = SEND_RELEASE;
          r.out_timestamp = lclock;
          dequeue(node_id);
          acks = 0;
        end
      end
      OP_REQUEST: begin
        r.list_overflow = !enqueue(it.sender_id, it.msg_timestamp);
        lclock = merged(it.msg_timestamp);
        r.send_kind     = SEND_RESP;
        r.dest_id       = it.sender_id;
        r.out_timestamp = lclock;
      end
      OP_RESP: begin
        if (acks < ACK_LIMIT) acks++;
        lclock = merged(it.msg_timestamp);
      end
      OP_RELEASE: begin
        dequeue(it.sender_id);
        lclock = merged(it.msg_timestamp);
      end
      default: ;
    endcase
    r.in_critical = holds_lock();
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("result %0d: %s is %0h, expected %0h", results, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      node_id = '0;
      peers   = '0;
      lclock  = '0;
      q_len   = 0;
      acks    = 0;
      pending_results.delete();
      errors    = 0;
      results   = 0;
      crit_seen = 0;
      rel_seen  = 0;
      ovf_seen  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_OWN_ID:     node_id = cfg_data[ID_W-1:0];
          CFG_PEER_COUNT: peers   = cfg_data[PEER_W-1:0];
          default: ;
        endcase
      end
      // Retire the result first: a request taken on the same edge is a later one.
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report("result with nothing expected, stamp", out_item.out_timestamp, '0);
        end else begin
          oldest = pending_results.pop_front();
          if (out_item.send_kind !== oldest.send_kind)
            report("send kind", 32'(out_item.send_kind), 32'(oldest.send_kind));
          if (out_item.dest_id !== oldest.dest_id)
            report("destination", 32'(out_item.dest_id), 32'(oldest.dest_id));
          if (out_item.out_timestamp !== oldest.out_timestamp)
            report("stamp", out_item.out_timestamp, oldest.out_timestamp);
          if (out_item.in_critical !== oldest.in_critical)
            report("critical flag", 32'(out_item.in_critical), 32'(oldest.in_critical));
          if (out_item.list_overflow !== oldest.list_overflow)
            report("overflow flag", 32'(out_item.list_overflow),
                   32'(oldest.list_overflow));
          if (oldest.in_critical) crit_seen++;
          if (oldest.list_overflow) ovf_seen++;
          if (oldest.send_kind == SEND_RELEASE) rel_seen++;
          results++;
        end
      end
      if (in_valid && !in_stall) pending_results = {pending_results, step_node(in_item)};
    end
    outstanding = pending_results.size();
    clock_now   = lclock;
    list_len    = q_len;
    list_head   = q_id[0];
    acks_now    = acks;
  end

endmodule

[tb/testbench.sv]
// Top of the Lamport mutex node testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import lmn_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int PHASES       = 8;
  localparam int TAIL         = 24;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  int                errors, outstanding, results, crit_seen, rel_seen, ovf_seen;
  int                list_len, acks_now;
  logic [TS_W-1:0]   clock_now;
  logic [ID_W-1:0]   list_head;
  int                driven, settings, tx_calm, rx_calm;
  logic [PEER_W-1:0] cur_peers;

  lamport_mutex_node_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lmn_checker watch (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding),
    .results     (results),
    .crit_seen   (crit_seen),
    .rel_seen    (rel_seen),
    .ovf_seen    (ovf_seen),
    .clock_now   (clock_now),
    .list_len    (list_len),
    .list_head   (list_head),
    .acks_now    (acks_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("run limit reached, %0d results still outstanding", outstanding);
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly random waits, with occasional stretches of back-to-back traffic.
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [ID_W-1:0] any_id();
    return ID_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [TS_W-1:0] any_stamp();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return clock_now + $urandom_range(0, 6) - 3;
    endcase
  endfunction

  initial begin
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      hold = pick_gap(rx_calm);
      out_stall <= (hold != 0);
      repeat (hold) @(negedge clk);
      if (hold != 0) out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  task automatic push(input logic [2:0] op, input logic [ID_W-1:0] from,
                      input logic [TS_W-1:0] stamp);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= '{operation: op, sender_id: from, msg_timestamp: stamp};
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
    if (op <= OP_RELEASE) driven++;
  endtask

  // Drain all results, then let the list walk finish before touching config.
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);
  endtask

  task automatic set_node(input logic [ID_W-1:0] own, input logic [PEER_W-1:0] peers);
    logic [CFG_DAT_W-PEER_W-1:0] junk;
    junk = (CFG_DAT_W-PEER_W)'($urandom_range(0, 15));
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OWN_ID;
    cfg_data  <= own;
    @(negedge clk);
    cfg_index <= CFG_PEER_COUNT;
    cfg_data  <= {junk, peers};
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_peers = peers;
    settings++;
  endtask

  task automatic flush_list();
    while (list_len != 0) push(OP_RELEASE, list_head, clock_now + $urandom_range(0, 2));
  endtask

  // Lock, collect the needed responses while rivals queue up, unlock, release rivals.
  task automatic lock_round();
    logic [ID_W-1:0] rivals[$];
    int want;
    push(OP_LOCK, any_id(), $urandom);
    want = (acks_now < cur_peers) ? cur_peers - acks_now : 0;
    if (want > 0 && $urandom_range(0, 5) == 0) want--;
    repeat (want) begin
      if ($urandom_range(0, 2) == 0) begin
        rivals = {rivals, any_id()};
        push(OP_REQUEST, rivals[$], clock_now + $urandom_range(0, 4));
      end
      push(OP_RESP, any_id(),
           $urandom_range(0, 1) ? clock_now + $urandom_range(0, 3)
                                : clock_now - $urandom_range(0, 3));
    end
    if (rivals.size() != 0 && $urandom_range(0, 3) == 0)
      push(OP_RELEASE, rivals.pop_front(), clock_now);
    push(OP_UNLOCK, any_id(), $urandom);
    while (rivals.size() != 0)
      push(OP_RELEASE, rivals.pop_front(), clock_now + $urandom_range(0, 2));
  endtask

  task automatic noise(input int n);
    logic [2:0] op;
    repeat (n) begin
      op = 3'($urandom_range(0, 7));
      // Hold back surplus responses so the node can still reach the critical section.
      if (op == OP_RESP && acks_now >= cur_peers) op = OP_RELEASE;
      push(op, any_id(), any_stamp());
    end
    if (list_len > 4 || $urandom_range(0, 1) == 0) flush_list();
  endtask

  task automatic fill_list();
    repeat (MAX_NODES + 2) push(OP_REQUEST, any_id(), any_stamp());
    flush_list();
  endtask

  initial begin
    logic [ID_W-1:0]   own;
    logic [PEER_W-1:0] peers;
    int                quota;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    driven    = 0;
    settings  = 0;
    tx_calm   = 0;
    rx_calm   = 0;
    cur_peers = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_node(8'd7, 4'd2);
    push(OP_UNLOCK, 8'h00, '0);
    push(3'd5, 8'hFF, '1);
    push(3'd6, 8'h00, '0);
    push(3'd7, 8'hA5, 32'h5A5A_A5A5);
    push(OP_RELEASE, 8'h00, '0);
    push(OP_LOCK, 8'hFF, '1);
    // Top stamp wraps the clock to zero.
    push(OP_REQUEST, 8'hFF, '1);
    push(OP_REQUEST, 8'h00, '1);
    push(OP_REQUEST, 8'h00, '1);
    push(OP_RESP, 8'h03, '0);
    push(OP_RESP, 8'h04, 32'h1);
    push(OP_UNLOCK, 8'h00, '0);
    push(OP_RELEASE, 8'h00, '1);
    push(OP_RELEASE, 8'hFF, '0);
    push(OP_RELEASE, 8'h00, '0);
    push(OP_LOCK, 8'h00, '0);
    push(OP_UNLOCK, 8'hFF, '1);
    push(OP_RESP, 8'h01, '0);
    push(OP_RESP, 8'h02, '0);
    push(OP_UNLOCK, 8'h00, '0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          own   = 8'h00;
          peers = 4'h0;
        end
        1: begin
          own   = 8'hFF;
          peers = 4'hF;
        end
        default: begin
          own   = any_id();
          peers = PEER_W'($urandom_range(0, 15));
        end
      endcase
      if (acks_now > peers) peers = PEER_W'(acks_now);
      set_node(own, peers);
      flush_list();
      quota = driven + RANDOM_ITEMS / PHASES;
      while (driven < quota) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: lock_round();
          6, 7:             noise($urandom_range(1, 6));
          8:                fill_list();
          default:          push(OP_RELEASE, any_id(), '1 - $urandom_range(0, 2));
        endcase
      end
    end

    // Drive the response count into saturation last: it blocks the lock for good.
    repeat ((1 << RESP_W) + 2) push(OP_RESP, any_id(), any_stamp());
    push(OP_LOCK, any_id(), $urandom);
    push(OP_UNLOCK, any_id(), $urandom);
    settle();

    $display("%0d requests over %0d node settings, %0d results checked",
             driven, settings, results);
    $display("%0d results in the critical section, %0d releases sent, %0d list overflows",
             crit_seen, rel_seen, ovf_seen);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
